// ----- rtl/core/prq_pkg.sv -----
// Package for the priority ready queue: operation codes and the control
// struct passed from the queue controller to each storage cell.
// No dependencies.
package prq_pkg;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    // Operation applied to the whole row of cells in the same cycle.
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

endpackage

// ----- rtl/core/priority_ready_queue_unit.sv -----
// Top level of the priority ready queue: a row of prq_cell slots, the
// occupancy counter and the registered result stage.
// Depends on prq_pkg and prq_cell.
//
// Usage: each input item is an insert (tuser = 0) carrying an identifier and
// a priority in tdata, or a remove (tuser = 1). Entries are kept sorted by
// descending priority in a shift-register row of cells; equal priorities
// leave in arrival order. An insert on a full queue is refused and reported
// as dropped; a remove on an empty queue reports nothing popped.
// Every item produces exactly one result item, carrying the popped entry,
// the popped and dropped flags and the occupancy after the item.
// A valid result appears in the cycle after acceptance. Throughput is one item
// per cycle while the receiver drains results: all cells compare against the
// new priority in parallel and shift in the same clock, so the row never stalls.
// The result sits in an output register; the block accepts the next item
// while that register is empty or being drained in the same cycle, so a
// stalled receiver stops input only after one result is waiting.
// Reset empties the queue and discards any pending result; slot contents
// are not cleared, since the occupancy count marks which slots are live.
module priority_ready_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int PRIO_BITS = 8,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int IN_DATA_W  = ((ID_BITS + PRIO_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((ID_BITS + PRIO_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input item channel.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // item_id, priority_req, zero fill
    input  logic                  i_s_axis_tuser,  // kind
    // Result item channel.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // out_id, out_priority, occupancy, zero fill
    output logic [1:0]            o_m_axis_tuser   // popped, dropped
);
    import prq_pkg::*;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [1:0]            r_out_user;

    logic                  w_accept;
    t_kind                 w_kind;
    logic [ID_BITS-1:0]    w_new_id;
    logic [PRIO_BITS-1:0]  w_new_prio;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_do_insert;
    logic                  w_do_remove;
    t_cell_ctrl            w_ctrl;

    logic [ID_BITS-1:0]    w_id   [DEPTH];
    logic [PRIO_BITS-1:0]  w_prio [DEPTH];
    logic                  w_stay [DEPTH];

    // The result register frees up when it is empty or drained this cycle.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_kind     = t_kind'(i_s_axis_tuser);
    assign w_new_id   = i_s_axis_tdata[ID_BITS-1:0];
    assign w_new_prio = i_s_axis_tdata[ID_BITS +: PRIO_BITS];

    assign w_full  = (r_count == FULL_COUNT);
    assign w_empty = (r_count == '0);

    assign w_do_insert = w_accept && (w_kind == KIND_INSERT) && !w_full;
    assign w_do_remove = w_accept && (w_kind == KIND_REMOVE) && !w_empty;

    assign w_ctrl.insert = w_do_insert;
    assign w_ctrl.remove = w_do_remove;

    // Row of cells; slot 0 is the head. Each cell sees its neighbors' contents
    // so that an insert shifts the tail down and a remove shifts it up.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 w_valid;
        logic                 w_prev_stay;
        logic [ID_BITS-1:0]   w_prev_id;
        logic [PRIO_BITS-1:0] w_prev_prio;
        logic [ID_BITS-1:0]   w_next_id;
        logic [PRIO_BITS-1:0] w_next_prio;

        assign w_valid = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            // Nothing ranks ahead of the head, so a new entry may land here.
            assign w_prev_stay = 1'b1;
            assign w_prev_id   = w_new_id;
            assign w_prev_prio = w_new_prio;
        end else begin : g_body
            assign w_prev_stay = w_stay[g-1];
            assign w_prev_id   = w_id[g-1];
            assign w_prev_prio = w_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            // The last slot falls out of the live range on a remove.
            assign w_next_id   = w_id[g];
            assign w_next_prio = w_prio[g];
        end else begin : g_inner
            assign w_next_id   = w_id[g+1];
            assign w_next_prio = w_prio[g+1];
        end

        prq_cell #(
            .ID_BITS   (ID_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_valid     (w_valid),
            .i_new_id    (w_new_id),
            .i_new_prio  (w_new_prio),
            .i_prev_stay (w_prev_stay),
            .i_prev_id   (w_prev_id),
            .i_prev_prio (w_prev_prio),
            .i_next_id   (w_next_id),
            .i_next_prio (w_next_prio),
            .o_stay      (w_stay[g]),
            .o_id        (w_id[g]),
            .o_prio      (w_prio[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the popped entry is read from the head before it shifts.
    always_comb begin
        n_out_data = '0;
        n_out_data[ID_BITS + PRIO_BITS +: CNT_W] = n_count;
        if (w_do_remove) begin
            n_out_data[ID_BITS-1:0]          = w_id[0];
            n_out_data[ID_BITS +: PRIO_BITS] = w_prio[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data    <= n_out_data;
            r_out_user[0] <= w_do_remove;
            r_out_user[1] <= (w_kind == KIND_INSERT) && w_full;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/core/prq_cell.sv -----
// One slot of the sorted queue: holds an identifier and a priority.
// Depends on prq_pkg.
module prq_cell #(
    parameter int ID_BITS   = 8,
    parameter int PRIO_BITS = 8
) (
    input  logic                    i_clk,
    input  prq_pkg::t_cell_ctrl     i_ctrl,
    input  logic                    i_valid,
    input  logic [ID_BITS-1:0]      i_new_id,
    input  logic [PRIO_BITS-1:0]    i_new_prio,
    input  logic                    i_prev_stay,
    input  logic [ID_BITS-1:0]      i_prev_id,
    input  logic [PRIO_BITS-1:0]    i_prev_prio,
    input  logic [ID_BITS-1:0]      i_next_id,
    input  logic [PRIO_BITS-1:0]    i_next_prio,
    output logic                    o_stay,
    output logic [ID_BITS-1:0]      o_id,
    output logic [PRIO_BITS-1:0]    o_prio
);
    import prq_pkg::*;

    logic [ID_BITS-1:0]   r_id;
    logic [PRIO_BITS-1:0] r_prio;
    logic [ID_BITS-1:0]   n_id;
    logic [PRIO_BITS-1:0] n_prio;

    // The entry here stays put on insert when it ranks at or above the new one.
    assign o_stay = i_valid && (r_prio >= i_new_prio);

    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        if (i_ctrl.remove) begin
            n_id   = i_next_id;
            n_prio = i_next_prio;
        end else if (i_ctrl.insert && !o_stay) begin
            if (i_prev_stay) begin
                n_id   = i_new_id;
                n_prio = i_new_prio;
            end else begin
                n_id   = i_prev_id;
                n_prio = i_prev_prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

    assign o_id   = r_id;
    assign o_prio = r_prio;

endmodule

// ----- rtl/core/prq_checker.sv -----
// Port-level checks for priority_ready_queue_unit, with the bind that
// attaches them. Depends on priority_ready_queue_unit.
module prq_checker #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int PRIO_BITS = 8,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int OUT_DATA_W = ((ID_BITS + PRIO_BITS + CNT_W + 7) / 8) * 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]            o_m_axis_tuser
);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0] w_occ;
    assign w_occ = o_m_axis_tdata[ID_BITS + PRIO_BITS +: CNT_W];

    // Every accepted item yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("accepted item produced no result");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

    // An item cannot both pop and be dropped.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("popped and dropped both set");

    // A drop happens only at full occupancy; a pop always leaves room.
    a_occ_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((!o_m_axis_tuser[1] || (w_occ == FULL_COUNT)) &&
             (!o_m_axis_tuser[0] || (w_occ != FULL_COUNT))))
        else $error("occupancy disagrees with result flags");

endmodule

bind priority_ready_queue_unit prq_checker #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS)
) u_prq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
